// ===== hw/rtl/dtb_pkg.sv =====
// shared types and codes for the draft tree builder
`default_nettype none
package dtb_pkg;

	// item actions
	typedef enum logic [2:0] {
		ACT_RESET   = 3'd0,
		ACT_SEED    = 3'd1,
		ACT_EXPAND  = 3'd2,
		ACT_ADVANCE = 3'd3,
		ACT_EXPORT  = 3'd4
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_ROOT  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_FRONT,
		S_NODE,
		S_FIN
	} state_t;

	localparam int TOKEN_W = 32;
	localparam int OUT_ID_W = 9;
	localparam int DEPTH_W = 8;
	localparam logic [OUT_ID_W-1:0] NONE_ID = '1;
	localparam logic [TOKEN_W-1:0] NONE_TOKEN = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

endpackage
`default_nettype wire

// ===== hw/rtl/dtb_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none
module dtb_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                   wdata,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output      logic [W-1:0]                   rdata
);
	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/draft_tree_builder.sv =====
// top level of the draft tree builder
// One word at a time: a word is taken only while the sequencer is idle and its result
// word lands in an output register, so the next word may enter while that result
// still waits. Reset-lane, seed, advance, a full table and words that do nothing
// pass through the front and finish states; expand with a live parent and room in
// the table, and export of a filled slot, also pass through the node state, because
// the node memory read depends on the frontier memory read. A stalled result word
// holds the sequencer in its last state until the output register frees up. Node
// contents (token, parent, depth) live in one memory of BATCH*TABLE_NODES entries;
// frontier node ids live in a second memory with two banks per lane that swap on
// advance, with per-slot valid flops giving the empty marks, so neither memory
// needs a clearing pass after reset.
`default_nettype none
module draft_tree_builder #(
	parameter int BATCH = 8,
	parameter int TREE_WIDTH = 16,
	parameter int TABLE_NODES = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [2:0]         action,
	input  wire logic [2:0]         lane,
	input  wire logic [3:0]         slot,
	input  wire logic [7:0]         width,
	input  wire logic signed [15:0] parent_slot,
	input  wire logic [7:0]         par_width,
	input  wire logic signed [31:0] token,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [1:0]         status,
	output      logic signed [8:0]  node_id,
	output      logic signed [31:0] token_out,
	output      logic signed [8:0]  parent_out,
	output      logic signed [8:0]  depth_out,
	output      logic [8:0]         count_out
);
	localparam int IDW = $clog2(TABLE_NODES);
	localparam int CW = $clog2(TABLE_NODES + 1);
	localparam int LW = BATCH > 1 ? $clog2(BATCH) : 1;
	localparam int SW = TREE_WIDTH > 1 ? $clog2(TREE_WIDTH) : 1;
	localparam int ND = BATCH * TABLE_NODES;
	localparam int NAW = $clog2(ND);
	localparam int FD = 2 * BATCH * TREE_WIDTH;
	localparam int FAW = $clog2(FD);
	localparam int INFO_W = dtb_pkg::TOKEN_W + 1 + IDW + dtb_pkg::DEPTH_W;

	// control state
	dtb_pkg::state_t state_q, state_nx;
	logic [CW-1:0] cnt_q [BATCH];
	logic sel_q [BATCH];
	logic [TREE_WIDTH-1:0] fv_q [BATCH][2];

	// item registers
	logic [2:0] act_q;
	logic [LW-1:0] lane_q;
	logic lane_ok_q;
	logic [3:0] slot_q;
	logic slot_ok_q;
	logic [7:0] uw_q;
	logic [dtb_pkg::TOKEN_W-1:0] tok_q;
	logic hit_q;
	logic [IDW-1:0] par_q;

	// result registers
	dtb_pkg::status_t res_status_q;
	logic [8:0] res_nid_q;
	logic [31:0] res_tok_q;
	logic [8:0] res_par_q;
	logic [8:0] res_dep_q;

	// memory ports
	logic fr_we;
	logic [FAW-1:0] fr_waddr, fr_raddr;
	logic [IDW-1:0] fr_wdata, fr_rdata;
	logic nd_we;
	logic [NAW-1:0] nd_waddr, nd_raddr;
	logic [INFO_W-1:0] nd_wdata, nd_rdata;

	// input decode
	logic lane_ok_c;
	logic [LW-1:0] lane_c;
	logic [7:0] uw_c, pw_c, ps_c;
	logic slot_ok_c;
	logic [SW-1:0] rd_slot_c;
	logic cur_c;

	always_comb begin
		lane_ok_c = 32'(lane) < BATCH;
		lane_c = lane_ok_c ? LW'(lane) : '0;
		uw_c = (32'(width) < TREE_WIDTH) ? width : 8'(TREE_WIDTH);
		slot_ok_c = 8'(slot) < uw_c;
		if (par_width == 8'd0) begin
			pw_c = 8'd1;
		end else if (32'(par_width) > TREE_WIDTH) begin
			pw_c = 8'(TREE_WIDTH);
		end else begin
			pw_c = par_width;
		end
		if (parent_slot < 0) begin
			ps_c = 8'd0;
		end else if (32'(parent_slot) > 32'(pw_c) - 1) begin
			ps_c = pw_c - 8'd1;
		end else begin
			ps_c = 8'(parent_slot);
		end
		rd_slot_c = (action == dtb_pkg::ACT_EXPORT) ? SW'(slot) : SW'(ps_c);
		cur_c = sel_q[lane_c];
		fr_raddr = FAW'((int'(lane_c) * 2 + int'(cur_c)) * TREE_WIDTH + int'(rd_slot_c));
	end

	// item decode in flight
	logic is_seed, is_expand, is_export, is_reset, is_advance, live;
	logic cur_bank, pend_bank;
	logic [CW-1:0] cnt_cur;
	logic full_c;
	logic [SW-1:0] slot_s;
	logic [IDW-1:0] nid_c;
	logic [dtb_pkg::DEPTH_W-1:0] par_dep, dep_c;
	logic alloc_c;

	always_comb begin
		is_seed = act_q == dtb_pkg::ACT_SEED;
		is_expand = act_q == dtb_pkg::ACT_EXPAND;
		is_export = act_q == dtb_pkg::ACT_EXPORT;
		is_reset = act_q == dtb_pkg::ACT_RESET;
		is_advance = act_q == dtb_pkg::ACT_ADVANCE;
		live = lane_ok_q && slot_ok_q;
		cur_bank = sel_q[lane_q];
		pend_bank = ~cur_bank;
		cnt_cur = cnt_q[lane_q];
		full_c = cnt_cur == CW'(TABLE_NODES);
		slot_s = SW'(slot_q);
		nid_c = IDW'(cnt_cur);
		par_dep = nd_rdata[dtb_pkg::DEPTH_W-1:0];
		dep_c = (par_dep == dtb_pkg::DEPTH_MAX) ? par_dep : par_dep + 1'b1;
		alloc_c = (state_q == dtb_pkg::S_FRONT && live && !full_c
			&& (is_seed || (is_expand && !hit_q)))
			|| (state_q == dtb_pkg::S_NODE && is_expand);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dtb_pkg::S_IDLE: begin
				if (in_valid) state_nx = dtb_pkg::S_FRONT;
			end
			dtb_pkg::S_FRONT: begin
				if ((live && hit_q && is_export) || (live && hit_q && is_expand && !full_c))
					state_nx = dtb_pkg::S_NODE;
				else
					state_nx = dtb_pkg::S_FIN;
			end
			dtb_pkg::S_NODE: state_nx = dtb_pkg::S_FIN;
			dtb_pkg::S_FIN: begin
				if (!out_valid || out_ready) state_nx = dtb_pkg::S_IDLE;
			end
			default: state_nx = dtb_pkg::S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		in_ready = state_q == dtb_pkg::S_IDLE;
		fr_we = alloc_c;
		fr_waddr = FAW'((int'(lane_q) * 2 + int'(pend_bank)) * TREE_WIDTH + int'(slot_s));
		fr_wdata = nid_c;
		nd_we = alloc_c;
		nd_waddr = NAW'(int'(lane_q) * TABLE_NODES + int'(nid_c));
		nd_raddr = NAW'(int'(lane_q) * TABLE_NODES + int'(fr_rdata));
		if (state_q == dtb_pkg::S_NODE)
			nd_wdata = {tok_q, 1'b1, par_q, dep_c};
		else
			nd_wdata = {tok_q, 1'b0, {IDW{1'b0}}, {dtb_pkg::DEPTH_W{1'b0}}};
	end

	// sequencer, counts, frontier valid flops, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtb_pkg::S_IDLE;
			out_valid <= 1'b0;
			for (int b = 0; b < BATCH; b++) begin
				cnt_q[b] <= '0;
				sel_q[b] <= 1'b0;
				fv_q[b][0] <= '0;
				fv_q[b][1] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (state_q == dtb_pkg::S_FIN && (!out_valid || out_ready))
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			if (alloc_c) begin
				cnt_q[lane_q] <= cnt_cur + 1'b1;
				fv_q[lane_q][pend_bank][slot_s] <= 1'b1;
			end
			if (state_q == dtb_pkg::S_FRONT && lane_ok_q) begin
				if (is_reset) begin
					cnt_q[lane_q] <= '0;
					fv_q[lane_q][0] <= '0;
					fv_q[lane_q][1] <= '0;
				end
				if (is_advance) begin
					for (int i = 0; i < TREE_WIDTH; i++) begin
						fv_q[lane_q][pend_bank][i] <= fv_q[lane_q][pend_bank][i]
							&& (i < int'(uw_q));
					end
					fv_q[lane_q][cur_bank] <= '0;
					sel_q[lane_q] <= pend_bank;
				end
				if ((is_seed || is_expand) && slot_ok_q && full_c)
					fv_q[lane_q][pend_bank][slot_s] <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			dtb_pkg::S_IDLE: begin
				act_q <= action;
				lane_q <= lane_c;
				lane_ok_q <= lane_ok_c;
				slot_q <= slot;
				slot_ok_q <= slot_ok_c;
				uw_q <= uw_c;
				tok_q <= token;
				hit_q <= fv_q[lane_c][cur_c][rd_slot_c];
				res_status_q <= dtb_pkg::STAT_DONE;
				res_nid_q <= dtb_pkg::NONE_ID;
				res_tok_q <= dtb_pkg::NONE_TOKEN;
				res_par_q <= dtb_pkg::NONE_ID;
				res_dep_q <= dtb_pkg::NONE_ID;
			end
			dtb_pkg::S_FRONT: begin
				par_q <= fr_rdata;
				if (live && (is_seed || is_expand)) begin
					if (full_c) begin
						res_status_q <= dtb_pkg::STAT_FULL;
					end else if (is_seed || !hit_q) begin
						res_nid_q <= 9'(nid_c);
						res_dep_q <= '0;
						if (is_expand) res_status_q <= dtb_pkg::STAT_ROOT;
					end
				end
				if (lane_ok_q && is_export) begin
					if (slot_ok_q && hit_q)
						res_nid_q <= 9'(fr_rdata);
					else
						res_status_q <= dtb_pkg::STAT_EMPTY;
				end
			end
			dtb_pkg::S_NODE: begin
				if (is_export) begin
					res_tok_q <= nd_rdata[INFO_W-1 -: dtb_pkg::TOKEN_W];
					res_par_q <= nd_rdata[dtb_pkg::DEPTH_W + IDW]
						? 9'(nd_rdata[dtb_pkg::DEPTH_W +: IDW]) : dtb_pkg::NONE_ID;
					res_dep_q <= 9'(par_dep);
				end else begin
					res_nid_q <= 9'(nid_c);
					res_dep_q <= 9'(dep_c);
				end
			end
			dtb_pkg::S_FIN: begin
				if (!out_valid || out_ready) begin
					status <= res_status_q;
					node_id <= res_nid_q;
					token_out <= res_tok_q;
					parent_out <= res_par_q;
					depth_out <= res_dep_q;
					count_out <= lane_ok_q ? 9'(cnt_cur) : 9'd0;
				end
			end
			default: begin
			end
		endcase
	end

	// frontier node ids, two banks per lane
	dtb_ram #(.W(IDW), .D(FD)) u_frontier (
		.clk   (clk),
		.we    (fr_we),
		.waddr (fr_waddr),
		.wdata (fr_wdata),
		.raddr (fr_raddr),
		.rdata (fr_rdata)
	);

	// node table: token, parent, depth
	dtb_ram #(.W(INFO_W), .D(ND)) u_nodes (
		.clk   (clk),
		.we    (nd_we),
		.waddr (nd_waddr),
		.wdata (nd_wdata),
		.raddr (nd_raddr),
		.rdata (nd_rdata)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/dtb_checker.sv =====
// port-level checks for the draft tree builder
`default_nettype none
module dtb_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [1:0]         status,
	input wire logic signed [8:0]  node_id,
	input wire logic signed [31:0] token_out,
	input wire logic signed [8:0]  parent_out,
	input wire logic signed [8:0]  depth_out
);
	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(node_id))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while busy");

	// empty export carries no node
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dtb_pkg::STAT_EMPTY |-> node_id == -9'sd1
		&& token_out == -32'sd1 && parent_out == -9'sd1 && depth_out == -9'sd1)
		else $error("empty export carries data");

	// full table allocates nothing
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dtb_pkg::STAT_FULL |-> node_id == -9'sd1 && depth_out == -9'sd1)
		else $error("full table reported a node");

	// orphan child is a depth zero root
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == dtb_pkg::STAT_ROOT |-> depth_out == 9'sd0 && node_id >= 0)
		else $error("orphan child not a root");
endmodule

bind draft_tree_builder dtb_checker u_dtb_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.node_id    (node_id),
	.token_out  (token_out),
	.parent_out (parent_out),
	.depth_out  (depth_out)
);
`default_nettype wire
